### hw/rtl/grwh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grwh_pkg
// shared types and constants for the grid ray wall hit list core
// ----------------------------------------------------------------------------
package grwh_pkg;

  localparam int FRAC_BITS    = 10;
  localparam int ANGLE_STEPS  = 5760;
  // 65536 / ANGLE_STEPS = 512 / 45, taken as a reciprocal multiply:
  // floor(a * 512 / 45) = floor(a * ceil(2^28 / 45) / 2^19) for every reduced angle
  localparam logic [22:0] ANGLE_RECIP       = 23'd5965233;
  localparam int          ANGLE_RECIP_SHIFT = 19;
  localparam int MAP_W_MAX    = 64;
  localparam int MAP_H_MAX    = 64;
  localparam int STORE_DEPTH  = MAP_W_MAX * MAP_H_MAX;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int DIVIDEND_W   = 17 + FRAC_BITS;
  localparam int DIVISOR_W    = 17;
  localparam int CORDIC_ITERS = 14;
  localparam int CORDIC_X0    = 39797;
  localparam logic [31:0] LEN_SAT = 32'hFFFF_FFFF;

  localparam logic [1:0] REG_MAX_DIST = 2'd0;
  localparam logic [1:0] REG_MAP_W    = 2'd1;
  localparam logic [1:0] REG_MAP_H    = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  function automatic logic [13:0] cordic_atan(input logic [3:0] idx);
    logic [13:0] v;
    unique case (idx)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/grwh_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grwh_map
// map cell store: wall flag and height, one write and one read port
// ----------------------------------------------------------------------------
module grwh_map (
  input  logic                      clk,
  input  logic                      we,
  input  logic [grwh_pkg::ADDR_W-1:0] waddr,
  input  logic [4:0]                wdata,
  input  logic [grwh_pkg::ADDR_W-1:0] raddr,
  output logic [4:0]                rdata
);
  import grwh_pkg::*;

  logic [4:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/grwh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grwh_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module grwh_div (
  input  logic                          clk,
  input  logic                          rst,
  input  grwh_pkg::div_req_t            req,
  output logic                          done,
  output logic [grwh_pkg::DIVIDEND_W-1:0] quotient
);
  import grwh_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic               run;
  logic [CNT_W-1:0]   cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvsr;
  logic [DIVISOR_W:0]   trial;
  logic                 ge;

  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run      <= 1'b1;
        cnt      <= CNT_W'(DIVIDEND_W);
        rem      <= '0;
        dvsr     <= req.divisor;
        quotient <= req.dividend;
      end else if (run) begin
        // remainder stays below the divisor, so it fits its width
        rem      <= ge ? DIVISOR_W'(trial - {1'b0, dvsr}) : DIVISOR_W'(trial);
        quotient <= {quotient[DIVIDEND_W-2:0], ge};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/grwh_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grwh_cordic
// iterative cordic, one rotation per cycle, gives q16 cosine and sine
// ----------------------------------------------------------------------------
module grwh_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [17:0] cos_q,
  output logic signed [17:0] sin_q
);
  import grwh_pkg::*;

  logic               run;
  logic [3:0]         iter;
  logic [1:0]         quad;
  logic signed [18:0] x, y;
  logic signed [16:0] z;
  logic signed [18:0] dx, dy;
  logic signed [16:0] at;
  logic [16:0]        xc, yc;

  assign dx = y >>> iter;
  assign dy = x >>> iter;
  assign at = $signed({3'b0, cordic_atan(iter)});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        iter <= '0;
        x    <= 19'(CORDIC_X0);
        y    <= '0;
        z    <= $signed({3'b0, angle[13:0]});
        quad <= angle[15:14];
      end else if (run) begin
        if (!z[16]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        iter <= iter + 1'b1;
        if (iter == 4'(CORDIC_ITERS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // clamp to [0, 1.0]
  always_comb begin
    if (x[18])                     xc = '0;
    else if (x > 19'sd65536)       xc = 17'd65536;
    else                           xc = x[16:0];
    if (y[18])                     yc = '0;
    else if (y > 19'sd65536)       yc = 17'd65536;
    else                           yc = y[16:0];
  end

  always_comb begin
    unique case (quad)
      2'd0: begin
        cos_q = $signed({1'b0, xc});
        sin_q = $signed({1'b0, yc});
      end
      2'd1: begin
        cos_q = -$signed({1'b0, yc});
        sin_q = $signed({1'b0, xc});
      end
      2'd2: begin
        cos_q = -$signed({1'b0, xc});
        sin_q = -$signed({1'b0, yc});
      end
      default: begin
        cos_q = $signed({1'b0, yc});
        sin_q = -$signed({1'b0, xc});
      end
    endcase
  end

endmodule

### hw/rtl/grid_ray_wall_hit_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_wall_hit_list_core
// dda ray walk through a stored wall map, one result per wall cell crossed
// ----------------------------------------------------------------------------
// a map write is done when the command is taken. a cast runs the angle
// multiply, 14 cordic rotations, two divisions in the shared divider and the
// prep states, then a step and a check state per cell walked, set by the single
// map read port. the final result, a miss if no wall was hit, shows as busy
// drops. hits stop at MAX_HITS, and results can come on consecutive cycles;
// the receiver cannot stall. after reset a clearing pass zeroes the map.
// ----------------------------------------------------------------------------
module grid_ray_wall_hit_list_core #(
  parameter int MAX_HITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [11:0] cell_index,
  input  logic        cell_is_wall,
  input  logic [3:0]  cell_height,
  input  logic [15:0] start_x,
  input  logic [15:0] start_y,
  input  logic [12:0] ray_angle,
  // results
  output logic        valid,
  output logic [16:0] distance,
  output logic [15:0] hit_x,
  output logic [15:0] hit_y,
  output logic [5:0]  cell_x,
  output logic [5:0]  cell_y,
  output logic [3:0]  wall_height,
  output logic        hit_valid,
  output logic        last,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import grwh_pkg::*;

  localparam int HIT_W = $clog2(MAX_HITS + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ANGLE, S_CORDIC, S_DIVX, S_DIVY,
    S_PREP_LEN, S_PREP_END, S_INIT, S_STEP, S_CHECK, S_FINISH
  } state_t;

  state_t state;

  // ---------------- configuration registers ----------------
  logic [16:0] max_distance;
  logic [6:0]  map_width;
  logic [6:0]  map_height;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= 17'd16384;
      map_width    <= 7'd64;
      map_height   <= 7'd64;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MAX_DIST: max_distance <= pwdata[16:0];
        REG_MAP_W:    map_width    <= pwdata[6:0];
        REG_MAP_H:    map_height   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_DIST: prdata = {15'b0, max_distance};
      REG_MAP_W:    prdata = {25'b0, map_width};
      REG_MAP_H:    prdata = {25'b0, map_height};
      default:      prdata = '0;
    endcase
  end

  // map size in use, saturated at the store size
  logic [6:0] w_use, h_use;
  assign w_use = (map_width  > 7'(MAP_W_MAX)) ? 7'(MAP_W_MAX) : map_width;
  assign h_use = (map_height > 7'(MAP_H_MAX)) ? 7'(MAP_H_MAX) : map_height;

  // ---------------- command acceptance ----------------
  logic accept;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // ---------------- map memory ----------------
  logic [ADDR_W-1:0] clr_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [4:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [4:0]        mem_rdata;

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = accept && !op;
      mem_waddr = cell_index;
      mem_wdata = {cell_is_wall, cell_height};
    end
  end

  grwh_map u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---------------- shared divider and cordic ----------------
  div_req_t              div_req;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_q;
  logic                  cor_start;
  logic [15:0]           cor_angle;
  logic                  cor_done;
  logic signed [17:0]    cor_cos, cor_sin;

  grwh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  grwh_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .cos_q (cor_cos),
    .sin_q (cor_sin)
  );

  // ---------------- ray registers ----------------
  logic [15:0]        sx, sy;
  logic [12:0]        ang;
  logic signed [17:0] c, s;
  logic [31:0]        stx, sty, lx, ly, ray_dist;
  logic signed [11:0] cx, cy, ex, ey;
  logic               dest;
  logic [HIT_W-1:0]   nhits;

  // pending hit, held until we know whether it is the final one
  logic        pend;
  logic [16:0] p_dist;
  logic [15:0] p_hx, p_hy;
  logic [5:0]  p_cx, p_cy;
  logic [3:0]  p_h;

  // ---------------- datapath ----------------
  logic [12:0]           ang_red;
  logic [35:0]           ang_prod;
  logic [16:0]           mag_c, mag_s;
  logic                  xneg, yneg;
  logic [10:0]           gap_x, gap_y;
  logic [42:0]           prod_lx, prod_ly;
  logic [31:0]           lx0, ly0;
  logic signed [35:0]    md_c, md_s;
  logic signed [37:0]    end_x, end_y;
  logic                  oob0, dest0;
  logic                  take_x;
  logic [32:0]           sum_lx, sum_ly;
  logic [31:0]           lx_n, ly_n;
  logic signed [11:0]    ncx, ncy;
  logic                  oob_n;
  logic [ADDR_W-1:0]     rd_addr;
  logic signed [50:0]    dc, ds;
  logic signed [35:0]    hx_s, hy_s;
  logic [15:0]           hx_c, hy_c;
  logic [16:0]           dist_c;
  logic                  wall;
  logic                  walk_end;

  assign ang_red = (ang >= 13'(ANGLE_STEPS)) ? 13'(ang - 13'(ANGLE_STEPS)) : ang;
  // binary angle = reduced angle * 512 / 45, by reciprocal multiply
  assign ang_prod = {23'b0, ang_red} * {13'b0, ANGLE_RECIP};

  assign mag_c = c[17] ? 17'(-c) : c[16:0];
  assign mag_s = s[17] ? 17'(-s) : s[16:0];
  // a zero component steps toward minus
  assign xneg  = c[17] || (c == 18'sd0);
  assign yneg  = s[17] || (s == 18'sd0);

  // distance to the first grid line on each axis
  assign gap_x   = xneg ? {1'b0, sx[FRAC_BITS-1:0]} : 11'(11'd1024 - {1'b0, sx[FRAC_BITS-1:0]});
  assign gap_y   = yneg ? {1'b0, sy[FRAC_BITS-1:0]} : 11'(11'd1024 - {1'b0, sy[FRAC_BITS-1:0]});
  assign prod_lx = gap_x * stx;
  assign prod_ly = gap_y * sty;
  assign lx0     = (prod_lx[42] != 1'b0) ? LEN_SAT : prod_lx[41:10];
  assign ly0     = (prod_ly[42] != 1'b0) ? LEN_SAT : prod_ly[41:10];

  // end cell of the full length ray
  assign md_c  = $signed({1'b0, max_distance}) * c;
  assign md_s  = $signed({1'b0, max_distance}) * s;
  assign end_x = $signed({6'b0, sx, 16'b0}) + 38'(md_c);
  assign end_y = $signed({6'b0, sy, 16'b0}) + 38'(md_s);

  assign oob0  = !((cx < $signed({5'b0, w_use})) && (cy < $signed({5'b0, h_use})));
  assign dest0 = (cx == ex) && (cy == ey);

  // one dda step, ties step in y
  assign take_x = lx < ly;
  assign sum_lx = {1'b0, lx} + {1'b0, stx};
  assign sum_ly = {1'b0, ly} + {1'b0, sty};
  assign lx_n   = sum_lx[32] ? LEN_SAT : sum_lx[31:0];
  assign ly_n   = sum_ly[32] ? LEN_SAT : sum_ly[31:0];
  assign ncx    = take_x ? (xneg ? cx - 12'sd1 : cx + 12'sd1) : cx;
  assign ncy    = take_x ? cy : (yneg ? cy - 12'sd1 : cy + 12'sd1);
  assign oob_n  = ncx[11] || ncy[11] || (ncx >= $signed({5'b0, w_use}))
                  || (ncy >= $signed({5'b0, h_use}));
  assign rd_addr   = {6'b0, ncy[5:0]} * {5'b0, w_use} + {6'b0, ncx[5:0]};
  assign mem_raddr = rd_addr;

  // hit point on the crossing, product shifted with floor rounding
  assign dc   = $signed({1'b0, ray_dist}) * c;
  assign ds   = $signed({1'b0, ray_dist}) * s;
  assign hx_s = $signed({20'b0, sx}) + $signed({dc[50], dc[50:16]});
  assign hy_s = $signed({20'b0, sy}) + $signed({ds[50], ds[50:16]});
  assign hx_c = hx_s[35] ? 16'd0 : ((hx_s > 36'sd65535) ? 16'hFFFF : hx_s[15:0]);
  assign hy_c = hy_s[35] ? 16'd0 : ((hy_s > 36'sd65535) ? 16'hFFFF : hy_s[15:0]);
  assign dist_c = (ray_dist > 32'h1FFFF) ? 17'h1FFFF : ray_dist[16:0];

  assign wall     = mem_rdata[4];
  assign walk_end = dest || (ray_dist >= {15'b0, max_distance});

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      valid     <= 1'b0;
      cor_start <= 1'b0;
      div_req   <= '0;
      pend      <= 1'b0;
      nhits     <= '0;
    end else begin
      valid         <= 1'b0;
      cor_start     <= 1'b0;
      div_req.start <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && op) begin
            sx    <= start_x;
            sy    <= start_y;
            ang   <= ray_angle;
            cx    <= {6'b0, start_x[15:FRAC_BITS]};
            cy    <= {6'b0, start_y[15:FRAC_BITS]};
            nhits <= '0;
            pend  <= 1'b0;
            state <= S_ANGLE;
          end
        end
        S_ANGLE: begin
          cor_start <= 1'b1;
          cor_angle <= ang_prod[ANGLE_RECIP_SHIFT+15:ANGLE_RECIP_SHIFT];
          state     <= S_CORDIC;
        end
        S_CORDIC: begin
          if (cor_done) begin
            c     <= cor_cos;
            s     <= cor_sin;
            state <= S_DIVX;
            div_req.start    <= 1'b1;
            div_req.dividend <= DIVIDEND_W'(1) << (16 + FRAC_BITS);
            div_req.divisor  <= cor_cos[17] ? 17'(-cor_cos) : cor_cos[16:0];
          end
        end
        S_DIVX: begin
          if (div_done) begin
            stx   <= (mag_c == '0) ? LEN_SAT : 32'(div_q);
            state <= S_DIVY;
            div_req.start    <= 1'b1;
            div_req.dividend <= DIVIDEND_W'(1) << (16 + FRAC_BITS);
            div_req.divisor  <= mag_s;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            sty   <= (mag_s == '0) ? LEN_SAT : 32'(div_q);
            state <= S_PREP_LEN;
          end
        end
        S_PREP_LEN: begin
          lx    <= lx0;
          ly    <= ly0;
          state <= S_PREP_END;
        end
        S_PREP_END: begin
          ex       <= end_x[37:26];
          ey       <= end_y[37:26];
          ray_dist <= '0;
          state    <= S_INIT;
        end
        S_INIT: begin
          if (oob0 || dest0 || (max_distance == '0)) begin
            state <= S_FINISH;
          end else begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          cx <= ncx;
          cy <= ncy;
          if (take_x) begin
            ray_dist <= lx;
            lx       <= lx_n;
          end else begin
            ray_dist <= ly;
            ly       <= ly_n;
          end
          dest <= (ncx == ex) && (ncy == ey);
          // map read issued here, data valid in the check cycle
          state <= oob_n ? S_FINISH : S_CHECK;
        end
        S_CHECK: begin
          if (wall) begin
            if (pend) begin
              valid       <= 1'b1;
              distance    <= p_dist;
              hit_x       <= p_hx;
              hit_y       <= p_hy;
              cell_x      <= p_cx;
              cell_y      <= p_cy;
              wall_height <= p_h;
              hit_valid   <= 1'b1;
              last        <= 1'b0;
            end
            pend   <= 1'b1;
            p_dist <= dist_c;
            p_hx   <= hx_c;
            p_hy   <= hy_c;
            p_cx   <= cx[5:0];
            p_cy   <= cy[5:0];
            p_h    <= mem_rdata[3:0];
            nhits  <= nhits + 1'b1;
            if (walk_end || (nhits + 1'b1 >= HIT_W'(MAX_HITS))) begin
              state <= S_FINISH;
            end else begin
              state <= S_STEP;
            end
          end else begin
            state <= walk_end ? S_FINISH : S_STEP;
          end
        end
        S_FINISH: begin
          valid <= 1'b1;
          last  <= 1'b1;
          if (pend) begin
            distance    <= p_dist;
            hit_x       <= p_hx;
            hit_y       <= p_hy;
            cell_x      <= p_cx;
            cell_y      <= p_cy;
            wall_height <= p_h;
            hit_valid   <= 1'b1;
          end else begin
            // ray hit nothing
            distance    <= '0;
            hit_x       <= '0;
            hit_y       <= '0;
            cell_x      <= '0;
            cell_y      <= '0;
            wall_height <= '0;
            hit_valid   <= 1'b0;
          end
          pend  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  // results only come out of a cast in progress or its final cycle
  a_valid_in_cast: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy))
    else $error("result strobe outside a cast");

  // the final result of a cast frees the command channel
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (valid && last) |-> !busy)
    else $error("busy after final result");

  // a miss result is alone and carries zero fields
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    (valid && !hit_valid) |-> (last && distance == '0 && wall_height == '0))
    else $error("malformed miss result");

  // the map memory is never written during a walk
  a_no_write_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP || state == S_CHECK) |-> !mem_we)
    else $error("map write during walk");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for grid_ray_wall_hit_list_core: map writes and ray
// casts go in through the command port, every wall hit coming back is
// compared with a cycle-free dda walk of the same map, register changes go
// through the apb port between phases
// ----------------------------------------------------------------------------
module tb;
  import grwh_pkg::*;

  localparam int HIT_LIMIT  = 64;
  localparam int STALL_MAX  = 20000;  // covers the clear pass too
  localparam int CLK_HALF   = 5;

  typedef struct packed {
    logic [16:0] distance;
    logic [15:0] hit_x;
    logic [15:0] hit_y;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [3:0]  wall_height;
    logic        hit_valid;
    logic        last;
  } wall_hit_t;

  // --------------------------------------------------------------------------
  // hit list predictor: owns a copy of the map and the registers
  // --------------------------------------------------------------------------
  class ray_scoreboard;
    bit          wall_bit [STORE_DEPTH];
    bit [3:0]    height_val [STORE_DEPTH];
    bit [16:0]   ray_limit;
    bit [6:0]    cols;
    bit [6:0]    rows;
    wall_hit_t   hits_due [$];
    int          rot_step [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
                                   10, 5, 3, 1};
    int          n_casts, n_writes, n_hits, n_misses, n_full;

    function new();
      ray_limit = 17'd16384;
      cols      = 7'd64;
      rows      = 7'd64;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_MAX_DIST: ray_limit = v[16:0];
        REG_MAP_W:    cols      = v[6:0];
        REG_MAP_H:    rows      = v[6:0];
        default: ;
      endcase
    endfunction

    // quadrant split, then cordic on the low 14 bits of a 16-bit binary angle
    function void sin_cos(logic [12:0] ang, output longint c, output longint s);
      longint b, x, y, z, dx, dy;
      int q;
      b = ((longint'(ang) % ANGLE_STEPS) * 65536) / ANGLE_STEPS;
      q = int'((b >> 14) & 3);
      x = CORDIC_X0;
      y = 0;
      z = b & 16'h3FFF;
      for (int i = 0; i < 14; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= rot_step[i];
        end else begin
          x += dx; y -= dy; z += rot_step[i];
        end
      end
      if (x < 0) x = 0;
      if (x > 65536) x = 65536;
      if (y < 0) y = 0;
      if (y > 65536) y = 65536;
      case (q)
        0: begin c = x;  s = y;  end
        1: begin c = -y; s = x;  end
        2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint clip_len(longint v);
      return (v > longint'(LEN_SAT)) ? longint'(LEN_SAT) : v;
    endfunction

    // length of ray per unit of travel along one axis
    function longint axis_step(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      if (m == 0) return longint'(LEN_SAT);
      return clip_len((longint'(1) << (16 + FRAC_BITS)) / m);
    endfunction

    function longint border_len(longint p, int dir, longint stp);
      longint frac, gap;
      frac = p & ((1 << FRAC_BITS) - 1);
      gap  = (dir < 0) ? frac : ((1 << FRAC_BITS) - frac);
      return clip_len((gap * stp) >> FRAC_BITS);
    endfunction

    function logic [15:0] along(longint p, longint d, longint dir);
      longint v;
      v = p + ((d * dir) >>> 16);
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
    endfunction

    function void walk_ray(logic [15:0] sx16, logic [15:0] sy16, logic [12:0] ang);
      longint c, s, sx, sy, md, w, h, ex, ey, cx, cy, stx, sty, lx, ly, ray_len, idx;
      int dx, dy, n;
      bit oob, at_end;
      wall_hit_t r;
      wall_hit_t found [$];
      sx = sx16;
      sy = sy16;
      md = ray_limit;
      w  = (cols > MAP_W_MAX) ? MAP_W_MAX : cols;
      h  = (rows > MAP_H_MAX) ? MAP_H_MAX : rows;
      sin_cos(ang, c, s);
      dx  = (c > 0) ? 1 : -1;
      dy  = (s > 0) ? 1 : -1;
      stx = axis_step(c);
      sty = axis_step(s);
      lx  = border_len(sx, dx, stx);
      ly  = border_len(sy, dy, sty);
      // end cell of the full length ray
      ex  = (sx * 65536 + md * c) >>> (16 + FRAC_BITS);
      ey  = (sy * 65536 + md * s) >>> (16 + FRAC_BITS);
      cx  = sx >> FRAC_BITS;
      cy  = sy >> FRAC_BITS;
      oob     = !(cx < w && cy < h);
      at_end  = (cx == ex && cy == ey);
      ray_len = 0;
      n       = 0;
      while (!oob && !at_end && ray_len < md) begin
        // ties step in y
        if (lx < ly) begin
          cx += dx; ray_len = lx; lx = clip_len(lx + stx);
        end else begin
          cy += dy; ray_len = ly; ly = clip_len(ly + sty);
        end
        oob = !(cx >= 0 && cx < w && cy >= 0 && cy < h);
        if (oob) break;
        at_end = (cx == ex && cy == ey);
        idx = cy * w + cx;
        if (wall_bit[idx]) begin
          r.distance    = (ray_len > 131071) ? 17'h1FFFF : ray_len[16:0];
          r.hit_x       = along(sx, ray_len, c);
          r.hit_y       = along(sy, ray_len, s);
          r.cell_x      = cx[5:0];
          r.cell_y      = cy[5:0];
          r.wall_height = height_val[idx];
          r.hit_valid   = 1'b1;
          r.last        = 1'b0;
          found = {found, r};
          n++;
          if (n >= HIT_LIMIT) break;
        end
      end
      if (n == 0) begin
        r = '0;
        r.last = 1'b1;
        found = {found, r};
        n_misses++;
      end else begin
        r = found[found.size() - 1];
        r.last = 1'b1;
        found[found.size() - 1] = r;
        if (n >= HIT_LIMIT) n_full++;
      end
      hits_due = {hits_due, found};
    endfunction

    function void note_item(logic o, logic [11:0] ci, logic wl, logic [3:0] ch,
                            logic [15:0] sx, logic [15:0] sy, logic [12:0] ang);
      if (!o) begin
        n_writes++;
        if (ci < STORE_DEPTH) begin
          wall_bit[ci]   = wl;
          height_val[ci] = ch;
        end
      end else begin
        n_casts++;
        walk_ray(sx, sy, ang);
      end
    endfunction

    // empty string when the result matches the oldest expectation
    function string check_result(wall_hit_t got);
      wall_hit_t want;
      string msg;
      if (hits_due.size() == 0)
        return $sformatf("result with nothing pending: %p", got);
      want = hits_due.pop_front();
      n_hits++;
      msg = "";
      if (got.distance != want.distance)
        msg = {msg, $sformatf(" distance %0d/%0d", got.distance, want.distance)};
      if (got.hit_x != want.hit_x)
        msg = {msg, $sformatf(" hit_x %0d/%0d", got.hit_x, want.hit_x)};
      if (got.hit_y != want.hit_y)
        msg = {msg, $sformatf(" hit_y %0d/%0d", got.hit_y, want.hit_y)};
      if (got.cell_x != want.cell_x)
        msg = {msg, $sformatf(" cell_x %0d/%0d", got.cell_x, want.cell_x)};
      if (got.cell_y != want.cell_y)
        msg = {msg, $sformatf(" cell_y %0d/%0d", got.cell_y, want.cell_y)};
      if (got.wall_height != want.wall_height)
        msg = {msg, $sformatf(" wall_height %0d/%0d", got.wall_height, want.wall_height)};
      if (got.hit_valid != want.hit_valid)
        msg = {msg, $sformatf(" hit_valid %0d/%0d", got.hit_valid, want.hit_valid)};
      if (got.last != want.last)
        msg = {msg, $sformatf(" last %0d/%0d", got.last, want.last)};
      if (msg != "") msg = {"result mismatch (got/want):", msg};
      return msg;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, dut
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        op = 1'b0;
  logic [11:0] cell_index = '0;
  logic        cell_is_wall = 1'b0;
  logic [3:0]  cell_height = '0;
  logic [15:0] start_x = '0;
  logic [15:0] start_y = '0;
  logic [12:0] ray_angle = '0;
  logic        valid;
  logic [16:0] distance;
  logic [15:0] hit_x;
  logic [15:0] hit_y;
  logic [5:0]  cell_x;
  logic [5:0]  cell_y;
  logic [3:0]  wall_height;
  logic        hit_valid;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  grid_ray_wall_hit_list_core #(.MAX_HITS(HIT_LIMIT)) u_dut (
    .clk, .rst, .start, .busy, .op, .cell_index, .cell_is_wall, .cell_height,
    .start_x, .start_y, .ray_angle, .valid, .distance, .hit_x, .hit_y,
    .cell_x, .cell_y, .wall_height, .hit_valid, .last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ray_scoreboard sb = new();
  int  n_errors = 0;
  int  stall_cycles = 0;
  bit  quiet = 1'b0;   // no sender gaps while set

  task automatic report(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  // results are on the ports for one cycle, sampled at the edge that ends it
  always @(posedge clk) begin
    string msg;
    if (!rst && valid) begin
      msg = sb.check_result({distance, hit_x, hit_y, cell_x, cell_y, wall_height,
                             hit_valid, last});
      if (msg != "") report(msg);
    end
  end

  // watchdog: any transaction on any port restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("watchdog: no transaction for %0d cycles", STALL_MAX);
      $display("[grid_ray_wall_hit_list_core] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // drivers; every task is entered just after a rising edge
  // --------------------------------------------------------------------------
  task automatic send_item(logic o, logic [11:0] ci, logic wl, logic [3:0] ch,
                           logic [15:0] sx, logic [15:0] sy, logic [12:0] ang);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    op           <= o;
    cell_index   <= ci;
    cell_is_wall <= wl;
    cell_height  <= ch;
    start_x      <= sx;
    start_y      <= sy;
    ray_angle    <= ang;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(o, ci, wl, ch, sx, sy, ang);
  endtask

  task automatic put_cell(int col, int row, logic wl, logic [3:0] ch);
    int w;
    w = int'(sb.cols);
    send_item(1'b0, 12'(row * w + col), wl, ch, 16'($urandom), 16'($urandom),
              13'($urandom));
  endtask

  task automatic cast(logic [15:0] sx, logic [15:0] sy, logic [12:0] ang);
    send_item(1'b1, 12'($urandom), 1'($urandom), 4'($urandom), sx, sy, ang);
  endtask

  // hold the sender off until every pending hit has come back, then let
  // the tail of the last transaction settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.hits_due.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic set_phase(logic [31:0] md, logic [31:0] w, logic [31:0] h);
    drain();
    reg_write(REG_MAX_DIST, md);
    reg_write(REG_MAP_W, w);
    reg_write(REG_MAP_H, h);
  endtask

  // random item: writes mostly inside the map in use, casts mostly from
  // inside it, a share of raw full-range values for the rest
  task automatic random_item();
    int w, h;
    logic [15:0] sx, sy;
    logic [12:0] ang;
    w = (sb.cols > MAP_W_MAX) ? MAP_W_MAX : int'(sb.cols);
    h = (sb.rows > MAP_H_MAX) ? MAP_H_MAX : int'(sb.rows);
    if ($urandom_range(0, 99) < 45) begin
      if (w > 0 && h > 0 && $urandom_range(0, 3) != 0)
        put_cell($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                 $urandom_range(0, 2) == 0, 4'($urandom));
      else
        send_item(1'b0, 12'($urandom), 1'($urandom), 4'($urandom), 16'($urandom),
                  16'($urandom), 13'($urandom));
    end else begin
      if (w > 0 && h > 0 && $urandom_range(0, 3) != 0) begin
        sx = 16'($urandom_range(0, w * 1024 - 1));
        sy = 16'($urandom_range(0, h * 1024 - 1));
      end else begin
        sx = 16'($urandom);
        sy = 16'($urandom);
      end
      ang = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
                                        : 13'($urandom_range(0, ANGLE_STEPS - 1));
      cast(sx, sy, ang);
    end
  endtask

  task automatic random_run(int n);
    repeat (n) random_item();
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset registers, 64 x 64 map, a few walls around (5,5)
    put_cell(10, 5, 1'b1, 4'd15);
    put_cell(5, 10, 1'b1, 4'd9);
    put_cell(3, 3, 1'b1, 4'd7);
    put_cell(2, 0, 1'b0, 4'd15);                    // height stored, no wall
    send_item(1'b0, 12'd4095, 1'b1, 4'd15, 16'hFFFF, 16'hFFFF, 13'h1FFF);
    send_item(1'b0, 12'd4094, 1'b0, 4'd0, 16'h0, 16'h0, 13'h0);
    cast(16'd5632, 16'd5632, 13'd0);                 // +x, sin zero
    cast(16'd5632, 16'd5632, 13'd1440);              // +y, cos zero
    cast(16'd5632, 16'd5632, 13'd2880);              // -x, no hit
    cast(16'd5632, 16'd5632, 13'd4320);              // -y
    cast(16'd5632, 16'd5632, 13'd3600);              // diagonal into (3,3)
    cast(16'd5632, 16'd5632, 13'd720);
    cast(16'd5632, 16'd5632, 13'd5759);
    cast(16'd5632, 16'd5632, 13'd8191);              // wraps past a full turn
    cast(16'd0, 16'd0, 13'd0);
    cast(16'd2048, 16'd0, 13'd2880);                 // starts in the non-wall cell
    cast(16'hFFFF, 16'hFFFF, 13'd3600);              // starts in the corner wall cell
    cast(16'd64000, 16'd64000, 13'd720);             // lands in the corner wall
    cast(16'd5120, 16'd5120, 13'd0);                 // start on a grid corner

    // random phases over register settings
    set_phase(32'd16384, 32'd64, 32'd64);
    random_run(30);
    drain();                                         // sender waits for all hits
    random_run(30);

    set_phase(32'd131071, 32'd64, 32'd64);           // longest ray
    quiet = 1'b1;
    random_run(40);
    quiet = 1'b0;

    set_phase(32'd0, 32'd64, 32'd64);                // no walk at all
    random_run(20);

    set_phase(32'd5000, 32'd8, 32'd8);
    random_run(40);

    set_phase(32'hFFFF_FFFF, 32'd127, 32'd100);      // oversized map registers
    random_run(50);

    set_phase(32'd3000, 32'd0, 32'd12);              // empty map
    random_run(15);

    set_phase(32'd40000, 32'd1, 32'd64);
    random_run(30);

    // two-row strip full of walls: shallow rays run into the hit limit
    set_phase(32'd131071, 32'd64, 32'd2);
    for (int r = 0; r < 2; r++)
      for (int k = 0; k < 64; k++) put_cell(k, r, 1'b1, 4'($urandom));
    repeat (20) cast(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                     13'($urandom_range(1, 25)));
    random_run(10);

    set_phase($urandom_range(1, 131071), $urandom_range(1, 64), $urandom_range(1, 64));
    random_run(40);

    drain();
    if (sb.hits_due.size() != 0) begin
      report($sformatf("%0d expected hits never came", sb.hits_due.size()));
    end
    $display("covered %0d casts and %0d map writes, %0d results checked",
             sb.n_casts, sb.n_writes, sb.n_hits);
    $display("rays with no hit: %0d, rays stopped by the hit limit: %0d",
             sb.n_misses, sb.n_full);
    if (n_errors == 0) begin
      $display("[grid_ray_wall_hit_list_core] OK");
    end else begin
      $display("[grid_ray_wall_hit_list_core] ERROR");
    end
    $finish;
  end

endmodule

### grid_ray_wall_hit_list_core.f
hw/rtl/grwh_pkg.sv
hw/rtl/grwh_map.sv
hw/rtl/grwh_div.sv
hw/rtl/grwh_cordic.sv
hw/rtl/grid_ray_wall_hit_list_core.sv
sim/tb.sv
